// File: sv/mos_pkg.sv
// ----------------------------------------------------------------------------
// mos_pkg
// Shared widths, defaults and types for the median-of-samples block.
// ----------------------------------------------------------------------------
package mos_pkg;

  // Field widths of a request and of a result.
  localparam int SAMPLE_W    = 32;
  localparam int MEDIAN_W    = 33;

  // Default capacity of the sorting chain.
  localparam int MAX_SAMPLES_DEF = 64;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;    // insert the broadcast sample in order
    logic shift;  // move every value one cell toward cell zero
  } cell_ctrl_t;

endpackage

// File: sv/mos_in_if.sv
// ----------------------------------------------------------------------------
// mos_in_if
// Sample channel: valid/ready handshake carrying one sample and a last flag.
// ----------------------------------------------------------------------------
interface mos_in_if import mos_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

// File: sv/mos_out_if.sv
// ----------------------------------------------------------------------------
// mos_out_if
// Result channel: valid/ready handshake carrying the median and overflow.
// ----------------------------------------------------------------------------
interface mos_out_if import mos_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [MEDIAN_W-1:0] median_half;
  logic                       overflow;

  modport source (output valid, output median_half, output overflow, input ready);
  modport sink   (input valid, input median_half, input overflow, output ready);
endinterface

// File: sv/mos_cell.sv
// ----------------------------------------------------------------------------
// mos_cell
// One cell of the insertion-sort chain: holds one sample of the sorted set.
// ----------------------------------------------------------------------------
module mos_cell import mos_pkg::*; (
  input  logic                       clk,
  input  cell_ctrl_t                 ctrl,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       occ,
  input  logic                       left_occ,
  input  logic                       left_gt,
  input  logic signed [SAMPLE_W-1:0] left_val,
  input  logic signed [SAMPLE_W-1:0] right_val,
  output logic signed [SAMPLE_W-1:0] val,
  output logic                       gt
);

  // The cell's value lies strictly above the new sample, so it must move up.
  assign gt = occ && (val > sample);

  // On insert, a moving cell or the first free cell takes either its left
  // neighbor's value (if that one moves too) or the new sample itself.
  // On shift, the value of the right neighbor moves in.
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      val <= right_val;
    end else if (ctrl.ins && (gt || (!occ && left_occ))) begin
      val <= left_gt ? left_val : sample;
    end
  end

endmodule

// File: sv/median_of_samples_top.sv
// ----------------------------------------------------------------------------
// median_of_samples_top
// Streaming median: samples are kept sorted in a chain of cells; on the last
// sample of a set the two middle values are shifted to the chain head and
// summed, giving the median in half units.
// ----------------------------------------------------------------------------
// Sequencing: a non-last sample only enters the chain. On the last sample of a
// set the chain is shifted toward the head until the lower middle value is in
// cell zero (one cell per cycle); after overflow no shifting is done.
// Throughput: one sample per cycle within a set; no sample is taken while a
// result is being formed. Reset (synchronous, rst high) empties the set and
// clears the result valid flag; cell contents are not cleared.
// ----------------------------------------------------------------------------
module median_of_samples_top import mos_pkg::*; #(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  mos_in_if.sink    samples,
  mos_out_if.source result
);

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int SH_W  = $clog2(MAX_SAMPLES);

  localparam logic [1:0] S_RUN   = 2'd0;
  localparam logic [1:0] S_DRAIN = 2'd1;
  localparam logic [1:0] S_SUM   = 2'd2;

  logic [1:0]       state;
  logic [CNT_W-1:0] count;
  logic             overflowed;
  logic [SH_W-1:0]  shifts;
  logic             odd;

  logic             accept;
  logic             full;
  logic [CNT_W-1:0] n_fin;
  logic [CNT_W-1:0] n_fin_m1;
  logic             out_free;
  cell_ctrl_t       ctrl;

  logic signed [SAMPLE_W-1:0] cell_val [MAX_SAMPLES];
  logic                       cell_gt  [MAX_SAMPLES];
  logic                       cell_occ [MAX_SAMPLES];

  logic signed [MEDIAN_W-1:0] mid_sum;

  // Request handshake and chain commands.
  assign samples.ready = (state == S_RUN);
  assign accept        = samples.valid && samples.ready;
  assign full          = (count == CNT_W'(MAX_SAMPLES));
  assign n_fin         = full ? count : count + CNT_W'(1);
  assign n_fin_m1      = n_fin - CNT_W'(1);
  assign out_free      = !result.valid || result.ready;
  assign ctrl.ins      = accept && !full;
  assign ctrl.shift    = (state == S_DRAIN) && (shifts != '0);

  // The chain of sorting cells.
  for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
    assign cell_occ[i] = (CNT_W'(i) < count);

    if (i == 0) begin : g_head
      mos_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .sample    (samples.sample),
        .occ       (cell_occ[i]),
        .left_occ  (1'b1),
        .left_gt   (1'b0),
        .left_val  (samples.sample),
        .right_val (cell_val[(i + 1) % MAX_SAMPLES]),
        .val       (cell_val[i]),
        .gt        (cell_gt[i])
      );
    end else if (i == MAX_SAMPLES - 1) begin : g_tail
      mos_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .sample    (samples.sample),
        .occ       (cell_occ[i]),
        .left_occ  (cell_occ[i-1]),
        .left_gt   (cell_gt[i-1]),
        .left_val  (cell_val[i-1]),
        .right_val (cell_val[i]),
        .val       (cell_val[i]),
        .gt        (cell_gt[i])
      );
    end else begin : g_mid
      mos_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .sample    (samples.sample),
        .occ       (cell_occ[i]),
        .left_occ  (cell_occ[i-1]),
        .left_gt   (cell_gt[i-1]),
        .left_val  (cell_val[i-1]),
        .right_val (cell_val[i+1]),
        .val       (cell_val[i]),
        .gt        (cell_gt[i])
      );
    end
  end

  // Sum of the two middle values, now at the head of the chain.
  always_comb begin
    mid_sum = {cell_val[0][SAMPLE_W-1], cell_val[0]};
    if (odd) begin
      mid_sum = mid_sum + {cell_val[0][SAMPLE_W-1], cell_val[0]};
    end else begin
      mid_sum = mid_sum + {cell_val[1][SAMPLE_W-1], cell_val[1]};
    end
  end

  // Set bookkeeping and result sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_RUN;
      count        <= '0;
      overflowed   <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      // The result is raised when formed and dropped once taken.
      if ((state == S_SUM) && out_free) begin
        result.valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        result.valid <= 1'b0;
      end
      unique case (state)
        S_RUN: begin
          if (accept) begin
            if (full) begin
              overflowed <= 1'b1;
            end else begin
              count <= count + CNT_W'(1);
            end
            if (samples.last) begin
              shifts <= SH_W'(n_fin_m1 >> 1);
              odd    <= n_fin[0];
              if (full || overflowed) begin
                state <= S_SUM;
              end else begin
                state <= S_DRAIN;
              end
            end
          end
        end
        S_DRAIN: begin
          if (shifts == '0) begin
            state <= S_SUM;
          end else begin
            shifts <= shifts - SH_W'(1);
          end
        end
        S_SUM: begin
          if (out_free) begin
            result.overflow    <= overflowed;
            result.median_half <= overflowed ? '0 : mid_sum;
            count              <= '0;
            overflowed         <= 1'b0;
            state              <= S_RUN;
          end
        end
        default: begin
          state <= S_RUN;
        end
      endcase
    end
  end

endmodule

// File: dv/median_of_samples_top_test.sv
// ----------------------------------------------------------------------------
// median_of_samples_top_test
// Self-checking bench for the streaming median block. Sets of signed samples
// are sent over the sample channel. An in-bench sorted list predicts each
// median in half units, or an overflow, and every result is checked in order.
// The run cycles through several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module median_of_samples_top_test;
  import mos_pkg::*;

  localparam int CAPACITY    = MAX_SAMPLES_DEF;
  localparam int RANDOM_GOAL = 1030;  // random samples, spread over four phases
  localparam int DRAIN_WAIT  = CAPACITY / 2 + 8;
  localparam int STALL_LIMIT = 4000;  // cycles with no request moving on any channel
  localparam int REPORT_MAX  = 10;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

  typedef struct {
    logic signed [MEDIAN_W-1:0] median_half;
    logic                       overflow;
  } median_result_t;

  // Keeps the current set sorted, forms the expected median on the last
  // sample, and compares each returned result with the oldest expectation.
  class median_checker;
    logic signed [SAMPLE_W-1:0] held_samples[$];
    logic                       set_overflowed;
    median_result_t             expected_medians[$];
    int capacity;
    int samples_noted;
    int sets_closed;
    int overflow_sets;
    int results_checked;
    int mismatches;

    function new(int cap);
      capacity        = cap;
      set_overflowed  = 1'b0;
      samples_noted   = 0;
      sets_closed     = 0;
      overflow_sets   = 0;
      results_checked = 0;
      mismatches      = 0;
    endfunction

    function void note_sample(logic signed [SAMPLE_W-1:0] s, logic is_last);
      int pos;
      median_result_t r;
      logic signed [MEDIAN_W-1:0] lower_mid;
      logic signed [MEDIAN_W-1:0] upper_mid;
      samples_noted++;
      // A new sample goes after any equal ones; a full store drops it.
      if (held_samples.size() < capacity) begin
        pos = held_samples.size();
        while (pos > 0 && held_samples[pos-1] > s) pos--;
        held_samples.insert(pos, s);
      end else begin
        set_overflowed = 1'b1;
      end
      if (!is_last) return;
      if (set_overflowed) begin
        r.median_half = '0;
        r.overflow    = 1'b1;
        overflow_sets++;
      end else begin
        // For an odd count both indexes land on the middle sample.
        lower_mid     = held_samples[(held_samples.size() - 1) / 2];
        upper_mid     = held_samples[held_samples.size() / 2];
        r.median_half = lower_mid + upper_mid;
        r.overflow    = 1'b0;
      end
      expected_medians.push_back(r);
      held_samples.delete();
      set_overflowed = 1'b0;
      sets_closed++;
    endfunction

    function void check_result(logic signed [MEDIAN_W-1:0] median_half, logic overflow);
      median_result_t r;
      results_checked++;
      if (expected_medians.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: unexpected result median_half=%0d overflow=%0b",
                   $realtime, median_half, overflow);
        return;
      end
      r = expected_medians.pop_front();
      if (median_half !== r.median_half || overflow !== r.overflow) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: result mismatch: expected median_half=%0d overflow=%0b, got %0d %0b",
                   $realtime, r.median_half, r.overflow, median_half, overflow);
      end
    endfunction

    function int pending();
      return expected_medians.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  mos_in_if  samples_if ();
  mos_out_if result_if ();

  median_of_samples_top #(
    .MAX_SAMPLES(CAPACITY)
  ) dut (
    .clk(clk),
    .rst(rst),
    .samples(samples_if),
    .result(result_if)
  );

  median_checker checker_h = new(CAPACITY);

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Sends one sample request, with random idle cycles ahead of it.
  task automatic send_sample(logic signed [SAMPLE_W-1:0] s, logic is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      samples_if.valid <= 1'b0;
      @(posedge clk);
    end
    samples_if.valid  <= 1'b1;
    samples_if.sample <= s;
    samples_if.last   <= is_last;
    do @(posedge clk); while (!samples_if.ready);
    checker_h.note_sample(s, is_last);
  endtask

  // Picks one sample of a set; the pattern decides how values relate.
  function automatic logic signed [SAMPLE_W-1:0] pick_sample(int pattern, int idx,
                                                             int base, int step);
    int v;
    case (pattern)
      0: v = $urandom;
      1: begin
        v = $urandom_range(8);
        v = v - 4;
      end
      2: begin
        case ($urandom_range(3))
          0: v = SAMPLE_MIN;
          1: v = SAMPLE_MAX;
          default: v = $urandom;
        endcase
      end
      3: v = base - idx * step;
      default: v = base + idx * step;
    endcase
    return v;
  endfunction

  // Sends one whole set; the first two sets of each phase overrun the store
  // by one and then fill it exactly.
  task automatic send_random_set(int set_idx, ref int sent);
    int n;
    int pick;
    int pattern;
    int base;
    int step;
    pick = $urandom_range(99);
    if (set_idx == 0)      n = CAPACITY + 1;
    else if (set_idx == 1) n = CAPACITY;
    else if (pick < 6)     n = CAPACITY + $urandom_range(1, 4);
    else if (pick < 20)    n = $urandom_range(CAPACITY - 16, CAPACITY);
    else                   n = $urandom_range(1, 12);
    pattern = $urandom_range(4);
    base    = $urandom;
    step    = $urandom_range(1, 1000);
    for (int i = 0; i < n; i++) begin
      send_sample(pick_sample(pattern, i, base, step), i == n - 1);
      sent++;
    end
  endtask

  // Result side: check each accepted result, then stall at random.
  initial begin
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_if.valid && result_if.ready)
        checker_h.check_result(result_if.median_half, result_if.overflow);
      result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: ends the run when no request moves for too long.
  initial begin
    forever begin
      @(posedge clk);
      if (rst || (samples_if.valid && samples_if.ready) ||
          (result_if.valid && result_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no request moved for %0d cycles", STALL_LIMIT);
        $display("median_of_samples_top regression: fail");
        $finish;
      end
    end
  end

  // Main sequence: reset, directed sets, then random sets in four phases.
  initial begin
    int sent;
    int phase_sent;
    int set_idx;
    rst               <= 1'b1;
    samples_if.valid  <= 1'b0;
    samples_if.sample <= '0;
    samples_if.last   <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    sent = 0;

    // Single-sample sets at both extremes.
    send_sample(SAMPLE_MIN, 1'b1);
    send_sample(SAMPLE_MAX, 1'b1);
    // Pairs at the extremes: the sum must not wrap.
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MAX, 1'b1);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MAX, 1'b1);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MIN, 1'b1);
    // Odd set with equal values out of order.
    send_sample(32'sd5, 1'b0);
    send_sample(-32'sd3, 1'b0);
    send_sample(32'sd5, 1'b1);
    // Even set with duplicates around zero.
    send_sample(32'sd0, 1'b0);
    send_sample(-32'sd1, 1'b0);
    send_sample(32'sd7, 1'b0);
    send_sample(-32'sd1, 1'b1);
    // Descending odd set: every sample moves to the chain head.
    send_sample(32'sd40, 1'b0);
    send_sample(32'sd30, 1'b0);
    send_sample(32'sd20, 1'b0);
    send_sample(32'sd10, 1'b0);
    send_sample(32'sd0, 1'b1);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      phase_sent = 0;
      set_idx = 0;
      while (phase_sent < RANDOM_GOAL / 4) begin
        send_random_set(set_idx, phase_sent);
        set_idx++;
      end
      sent += phase_sent;
    end
    samples_if.valid <= 1'b0;

    while (checker_h.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d samples in %0d sets (%0d random), %0d of them overrunning the store.",
             checker_h.samples_noted, checker_h.sets_closed, sent, checker_h.overflow_sets);
    $display("Checked %0d results under four idling patterns; %0d mismatches, %0d left over.",
             checker_h.results_checked, checker_h.mismatches, checker_h.pending());
    if (checker_h.mismatches == 0 && checker_h.pending() == 0) begin
      $display("median_of_samples_top regression: pass");
    end else begin
      $display("median_of_samples_top regression: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/mos_pkg.sv
sv/mos_in_if.sv
sv/mos_out_if.sv
sv/mos_cell.sv
sv/median_of_samples_top.sv
dv/median_of_samples_top_test.sv
